/* hw/rtl/sdspi_pkg.sv */
package sdspi_pkg;

    typedef enum logic [3:0] {
        P_IDLE, P_INIT_CLK, P_CMD_BYTES, P_CMD_POLL, P_OCR8, P_OCR58,
        P_RD_TOKEN, P_RD_DATA, P_RD_CRC, P_RD_END, P_WR_DATA, P_WR_CRC1,
        P_WR_CRC2, P_WR_RESP, P_WR_CHECK, P_WR_STOPPED
    } t_phase;

    typedef enum logic [3:0] {
        R_NONE, R_CMD0, R_CMD8, R_A55, R_A41, R_CMD58, R_V1_55, R_V1_41,
        R_LOOP55, R_LOOP, R_CMD16, R_RD, R_WR, R_STOP
    } t_ret;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_ERROR   = 2'd1;
    localparam logic [1:0] RC_NOTRDY  = 2'd2;
    localparam logic [1:0] RC_PARAM   = 2'd3;

    localparam logic [0:0] CFG_RESPONSE_TRIES = 1'd0;
    localparam logic [0:0] CFG_TOKEN_TRIES    = 1'd1;

    localparam logic [7:0]  RESET_RESPONSE_TRIES = 8'd10;
    localparam logic [15:0] RESET_TOKEN_TRIES    = 16'd20000;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       card_select;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       want_write_byte;
        logic       done_res;
        logic [1:0] result_code;
        logic [2:0] card_type;
        logic       not_initialized;
    } t_result;

endpackage

/* hw/rtl/sd_card_spi_host_engine_unit.sv */
// SD card SPI-mode host engine.
// Input channel (i_valid/o_ready): one item per SPI exchange or request.
// opcode 1/2/3 starts init, read or write while idle; opcode 0 brings the
// byte the card returned for the exchange requested by the previous result.
// Output channel (o_valid/i_ready): one result item per input item, holding
// the next exchange (tx byte and chip select), a received data byte, the
// write-byte request, the done flag with its code, and the card status.
// An item's result is registered at the edge that accepts it. Throughput
// is one item per cycle if not stalled; the next state is formed by one pass
// of the phase decoder between the state registers and the result register.
// When the receiver stalls, the result register holds and o_ready drops
// until the held item is taken; no item is lost or repeated.
// Reset (synchronous, active low) returns to idle with no card initialised,
// response tries 10 and token tries 20000. Configuration writes on
// i_cfg_we/i_cfg_index/i_cfg_data take effect at once; issue them only
// while no item is in flight.
module sd_card_spi_host_engine_unit #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_write_byte,
    input  logic [31:0] i_sector,
    input  logic [15:0] i_block_count,
    input  logic [7:0]  i_drive_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_card_select,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_want_write_byte,
    output logic        o_done_res,
    output logic [1:0]  o_result_code,
    output logic [2:0]  o_card_type,
    output logic        o_not_initialized,
    output logic        o_high_speed
);

    logic [7:0]  r_response_tries;
    logic [15:0] r_token_tries;
    logic        step;
    logic        can_load;
    sdspi_pkg::t_result core_res, out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_tries <= sdspi_pkg::RESET_RESPONSE_TRIES;
            r_token_tries    <= sdspi_pkg::RESET_TOKEN_TRIES;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sdspi_pkg::CFG_RESPONSE_TRIES)
                r_response_tries <= i_cfg_data[7:0];
            else
                r_token_tries <= i_cfg_data;
        end
    end

    assign o_ready = can_load;
    assign step    = i_valid && can_load;

    sdspi_core #(.BLOCK_BYTES(BLOCK_BYTES)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_opcode(i_opcode), .i_rx_byte(i_rx_byte), .i_write_byte(i_write_byte),
        .i_sector(i_sector), .i_block_count(i_block_count),
        .i_drive_number(i_drive_number),
        .i_response_tries(r_response_tries), .i_token_tries(r_token_tries),
        .o_result(core_res)
    );

    sdspi_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(step), .i_result(core_res),
        .i_ready(i_ready), .o_valid(o_valid), .o_can_load(can_load),
        .o_result(out_res)
    );

    assign o_tx_valid        = out_res.tx_valid;
    assign o_tx_byte         = out_res.tx_byte;
    assign o_card_select     = out_res.card_select;
    assign o_read_valid      = out_res.read_valid;
    assign o_read_byte       = out_res.read_byte;
    assign o_want_write_byte = out_res.want_write_byte;
    assign o_done_res        = out_res.done_res;
    assign o_result_code     = out_res.result_code;
    assign o_card_type       = out_res.card_type;
    assign o_not_initialized = out_res.not_initialized;
    assign o_high_speed      = !out_res.not_initialized;

endmodule

/* hw/rtl/sdspi_core.sv */
module sdspi_core #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [1:0]             i_opcode,
    input  logic [7:0]             i_rx_byte,
    input  logic [7:0]             i_write_byte,
    input  logic [31:0]            i_sector,
    input  logic [15:0]            i_block_count,
    input  logic [7:0]             i_drive_number,
    input  logic [7:0]             i_response_tries,
    input  logic [15:0]            i_token_tries,
    output sdspi_pkg::t_result     o_result
);

    localparam int CW = $clog2(BLOCK_BYTES + 1);

    sdspi_pkg::t_phase r_phase, n_phase;
    sdspi_pkg::t_ret   r_ret, n_ret;
    logic [2:0]  r_kind, n_kind;
    logic        r_uninit, n_uninit;
    logic [CW-1:0] r_bc, n_bc;
    logic [15:0] r_poll, n_poll;
    logic [5:0]  r_cmd, n_cmd;
    logic [31:0] r_arg, n_arg;
    logic [31:0] r_resp, n_resp;
    logic [15:0] r_blocks, n_blocks;
    sdspi_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sdspi_pkg::P_IDLE;
            r_ret    <= sdspi_pkg::R_NONE;
            r_kind   <= '0;
            r_uninit <= 1'b1;
            r_bc     <= '0;
            r_poll   <= '0;
            r_cmd    <= '0;
            r_arg    <= '0;
            r_resp   <= '0;
            r_blocks <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_ret    <= n_ret;
            r_kind   <= n_kind;
            r_uninit <= n_uninit;
            r_bc     <= n_bc;
            r_poll   <= n_poll;
            r_cmd    <= n_cmd;
            r_arg    <= n_arg;
            r_resp   <= n_resp;
            r_blocks <= n_blocks;
        end
    end

    function automatic logic [7:0] cmd_byte(input logic [CW-1:0] k, input logic [5:0] idx,
                                            input logic [31:0] arg);
        unique case (k)
            CW'(0):  cmd_byte = {2'b01, idx};
            CW'(1):  cmd_byte = arg[31:24];
            CW'(2):  cmd_byte = arg[23:16];
            CW'(3):  cmd_byte = arg[15:8];
            CW'(4):  cmd_byte = arg[7:0];
            default: cmd_byte = (idx == 6'd0) ? 8'h95 : (idx == 6'd8) ? 8'h87 : 8'h01;
        endcase
    endfunction

    logic [31:0] resp_sh;
    logic [15:0] blk_dec;
    logic [31:0] xfer_addr;
    logic [15:0] ttries;
    logic [7:0]  rtries;
    logic        fin_flag;

    assign resp_sh  = {r_resp[23:0], i_rx_byte};
    assign blk_dec  = (r_blocks != 16'd0) ? r_blocks - 16'd1 : r_blocks;
    // byte address wraps at 32 bits
    assign xfer_addr = r_kind[2] ? i_sector : i_sector * 32'(BLOCK_BYTES);
    assign rtries = i_response_tries;
    assign ttries = i_token_tries;

    always_comb begin
        n_phase = r_phase; n_ret = r_ret; n_kind = r_kind; n_uninit = r_uninit;
        n_bc = r_bc; n_poll = r_poll; n_cmd = r_cmd; n_arg = r_arg;
        n_resp = r_resp; n_blocks = r_blocks;
        res = '0;
        fin_flag = 1'b0;

        unique case (r_phase)
            sdspi_pkg::P_IDLE: begin
                if (i_opcode == sdspi_pkg::OP_INIT) begin
                    if (i_drive_number != 8'd0) begin
                        res.done_res = 1'b1; res.result_code = sdspi_pkg::RC_PARAM;
                    end else begin
                        n_kind = '0; n_uninit = 1'b1; n_bc = CW'(1);
                        n_phase = sdspi_pkg::P_INIT_CLK;
                        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
                    end
                end else if (i_opcode == sdspi_pkg::OP_READ ||
                             i_opcode == sdspi_pkg::OP_WRITE) begin
                    if (i_drive_number != 8'd0 || i_block_count == 16'd0) begin
                        res.done_res = 1'b1; res.result_code = sdspi_pkg::RC_PARAM;
                    end else if (r_uninit) begin
                        res.done_res = 1'b1; res.result_code = sdspi_pkg::RC_NOTRDY;
                    end else begin
                        n_blocks = i_block_count;
                        n_arg = xfer_addr; n_bc = '0; n_phase = sdspi_pkg::P_CMD_BYTES;
                        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
                        if (i_opcode == sdspi_pkg::OP_WRITE) begin
                            n_ret = sdspi_pkg::R_WR;
                            n_cmd = (i_block_count == 16'd1) ? 6'd24 : 6'd25;
                        end else begin
                            n_ret = sdspi_pkg::R_RD;
                            n_cmd = (i_block_count == 16'd1) ? 6'd17 : 6'd18;
                        end
                    end
                end
            end
            sdspi_pkg::P_INIT_CLK: begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
                if (r_bc < CW'(10)) begin
                    n_bc = r_bc + CW'(1);
                end else begin
                    n_cmd = 6'd0; n_arg = '0; n_ret = sdspi_pkg::R_CMD0;
                    n_bc = '0; n_phase = sdspi_pkg::P_CMD_BYTES;
                end
            end
            sdspi_pkg::P_CMD_BYTES: begin
                res.tx_valid = 1'b1; res.card_select = 1'b1;
                if (r_bc < CW'(6)) begin
                    res.tx_byte = cmd_byte(r_bc, r_cmd, r_arg);
                    n_bc = r_bc + CW'(1);
                end else begin
                    res.tx_byte = 8'hFF; n_poll = 16'd1; n_phase = sdspi_pkg::P_CMD_POLL;
                end
            end
            sdspi_pkg::P_CMD_POLL: begin
                if (i_rx_byte[7] && r_poll < {8'd0, rtries}) begin
                    n_poll = r_poll + 16'd1;
                    res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                end else begin
                    // default: issue a new command with the chosen index
                    res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
                    n_bc = '0; n_arg = '0; n_phase = sdspi_pkg::P_CMD_BYTES;
                    unique case (r_ret)
                        sdspi_pkg::R_CMD0:
                            if (i_rx_byte == 8'd1) begin
                                n_cmd = 6'd8; n_arg = 32'h1AA; n_ret = sdspi_pkg::R_CMD8;
                            end else fin_flag = 1'b1;
                        sdspi_pkg::R_CMD8:
                            if (i_rx_byte == 8'd1) begin
                                n_resp = '0; n_phase = sdspi_pkg::P_OCR8;
                                res.card_select = 1'b1;
                            end else begin
                                n_cmd = 6'd55; n_ret = sdspi_pkg::R_V1_55;
                            end
                        sdspi_pkg::R_A55:
                            if (i_rx_byte <= 8'd1) begin
                                n_cmd = 6'd41; n_arg = 32'h4000_0000; n_ret = sdspi_pkg::R_A41;
                            end else begin
                                n_cmd = 6'd58; n_ret = sdspi_pkg::R_CMD58;
                            end
                        sdspi_pkg::R_A41:
                            if (i_rx_byte != 8'd0) begin
                                n_cmd = 6'd55; n_ret = sdspi_pkg::R_A55;
                            end else begin
                                n_cmd = 6'd58; n_ret = sdspi_pkg::R_CMD58;
                            end
                        sdspi_pkg::R_CMD58:
                            if (i_rx_byte == 8'd0) begin
                                n_resp = '0; n_phase = sdspi_pkg::P_OCR58;
                                res.card_select = 1'b1;
                            end else fin_flag = 1'b1;
                        sdspi_pkg::R_V1_55:
                            if (i_rx_byte <= 8'd1) begin
                                n_cmd = 6'd41; n_ret = sdspi_pkg::R_V1_41;
                            end else begin
                                n_kind = 3'd1; n_cmd = 6'd1; n_ret = sdspi_pkg::R_LOOP;
                            end
                        sdspi_pkg::R_V1_41:
                            if (i_rx_byte <= 8'd1) begin
                                n_kind = 3'd2; n_cmd = 6'd55; n_ret = sdspi_pkg::R_LOOP55;
                            end else begin
                                n_kind = 3'd1; n_cmd = 6'd1; n_ret = sdspi_pkg::R_LOOP;
                            end
                        sdspi_pkg::R_LOOP55:
                            if (i_rx_byte > 8'd1) begin
                                n_cmd = 6'd55; n_ret = sdspi_pkg::R_LOOP55;
                            end else begin
                                n_cmd = 6'd41; n_ret = sdspi_pkg::R_LOOP;
                            end
                        sdspi_pkg::R_LOOP:
                            if (i_rx_byte == 8'd0) begin
                                n_cmd = 6'd16; n_arg = 32'(BLOCK_BYTES);
                                n_ret = sdspi_pkg::R_CMD16;
                            end else if (r_kind == 3'd2) begin
                                n_cmd = 6'd55; n_ret = sdspi_pkg::R_LOOP55;
                            end else begin
                                n_cmd = 6'd1; n_ret = sdspi_pkg::R_LOOP;
                            end
                        sdspi_pkg::R_CMD16: begin
                            if (i_rx_byte != 8'd0) n_kind = '0;
                            fin_flag = 1'b1;
                        end
                        sdspi_pkg::R_RD:
                            if (i_rx_byte == 8'd0) begin
                                n_poll = 16'd1; n_phase = sdspi_pkg::P_RD_TOKEN;
                                n_arg = r_arg; res.card_select = 1'b1;
                            end else begin
                                res = '0; res.done_res = 1'b1;
                                res.result_code = sdspi_pkg::RC_ERROR;
                                n_phase = sdspi_pkg::P_IDLE; n_bc = r_bc; n_arg = r_arg;
                            end
                        sdspi_pkg::R_WR:
                            if (i_rx_byte == 8'd0) begin
                                n_bc = '0; n_phase = sdspi_pkg::P_WR_DATA; n_arg = r_arg;
                                res.tx_byte = 8'hFC; res.card_select = 1'b1;
                                res.want_write_byte = 1'b1;
                            end else begin
                                res = '0; res.done_res = 1'b1;
                                res.result_code = sdspi_pkg::RC_ERROR;
                                n_phase = sdspi_pkg::P_IDLE; n_bc = r_bc; n_arg = r_arg;
                            end
                        sdspi_pkg::R_STOP: begin
                            res = '0; res.done_res = 1'b1;
                            res.result_code = (r_blocks != 16'd0) ? sdspi_pkg::RC_ERROR
                                                                  : sdspi_pkg::RC_OK;
                            n_phase = sdspi_pkg::P_IDLE; n_bc = r_bc; n_arg = r_arg;
                        end
                        default: begin
                            res = '0; res.done_res = 1'b1;
                            res.result_code = sdspi_pkg::RC_ERROR;
                            n_phase = sdspi_pkg::P_IDLE; n_bc = r_bc; n_arg = r_arg;
                        end
                    endcase
                    if (fin_flag) begin
                        // finish init: undo the speculative command issue
                        n_bc = r_bc; n_arg = r_arg;
                    end
                end
            end
            sdspi_pkg::P_OCR8, sdspi_pkg::P_OCR58: begin
                n_resp = resp_sh;
                n_bc = r_bc + CW'(1);
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                if (r_bc + CW'(1) >= CW'(4)) begin
                    if (r_phase == sdspi_pkg::P_OCR8) begin
                        if (resp_sh[15:0] == 16'h01AA) begin
                            res.card_select = 1'b0;
                            n_cmd = 6'd55; n_arg = '0; n_ret = sdspi_pkg::R_A55;
                            n_bc = '0; n_phase = sdspi_pkg::P_CMD_BYTES;
                        end else fin_flag = 1'b1;
                    end else begin
                        n_kind = resp_sh[30] ? 3'd6 : 3'd2;
                        fin_flag = 1'b1;
                    end
                end
            end
            sdspi_pkg::P_RD_TOKEN: begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                if (i_rx_byte == 8'hFF && r_poll < ttries) begin
                    n_poll = r_poll + 16'd1;
                end else if (i_rx_byte == 8'hFE) begin
                    n_bc = '0; n_phase = sdspi_pkg::P_RD_DATA;
                end else if (r_cmd == 6'd17) begin
                    res = '0; res.done_res = 1'b1; res.result_code = sdspi_pkg::RC_ERROR;
                    n_phase = sdspi_pkg::P_IDLE;
                end else begin
                    res.card_select = 1'b0;
                    n_cmd = 6'd12; n_arg = '0; n_ret = sdspi_pkg::R_STOP;
                    n_bc = '0; n_phase = sdspi_pkg::P_CMD_BYTES;
                end
            end
            sdspi_pkg::P_RD_DATA: begin
                res.read_valid = 1'b1; res.read_byte = i_rx_byte;
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                n_bc = r_bc + CW'(1);
                if (r_bc + CW'(1) >= CW'(BLOCK_BYTES)) n_phase = sdspi_pkg::P_RD_CRC;
            end
            sdspi_pkg::P_RD_CRC: begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                n_phase = sdspi_pkg::P_RD_END;
            end
            sdspi_pkg::P_RD_END: begin
                n_blocks = blk_dec;
                if (r_cmd == 6'd17) begin
                    res.done_res = 1'b1; res.result_code = sdspi_pkg::RC_OK;
                    n_phase = sdspi_pkg::P_IDLE;
                end else if (blk_dec != 16'd0) begin
                    res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                    n_poll = 16'd1; n_phase = sdspi_pkg::P_RD_TOKEN;
                end else begin
                    res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
                    n_cmd = 6'd12; n_arg = '0; n_ret = sdspi_pkg::R_STOP;
                    n_bc = '0; n_phase = sdspi_pkg::P_CMD_BYTES;
                end
            end
            sdspi_pkg::P_WR_DATA: begin
                res.tx_valid = 1'b1; res.tx_byte = i_write_byte; res.card_select = 1'b1;
                n_bc = r_bc + CW'(1);
                if (r_bc + CW'(1) < CW'(BLOCK_BYTES)) res.want_write_byte = 1'b1;
                else n_phase = sdspi_pkg::P_WR_CRC1;
            end
            sdspi_pkg::P_WR_CRC1: begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                n_phase = sdspi_pkg::P_WR_CRC2;
            end
            sdspi_pkg::P_WR_CRC2: begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                n_phase = sdspi_pkg::P_WR_RESP;
            end
            sdspi_pkg::P_WR_RESP: begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.card_select = 1'b1;
                n_phase = sdspi_pkg::P_WR_CHECK;
            end
            sdspi_pkg::P_WR_CHECK: begin
                if (i_rx_byte[4:0] == 5'h05) begin
                    n_blocks = blk_dec;
                    if (r_cmd == 6'd24) begin
                        res.done_res = 1'b1; res.result_code = sdspi_pkg::RC_OK;
                        n_phase = sdspi_pkg::P_IDLE;
                    end else if (blk_dec != 16'd0) begin
                        res.tx_valid = 1'b1; res.tx_byte = 8'hFC; res.card_select = 1'b1;
                        res.want_write_byte = 1'b1;
                        n_bc = '0; n_phase = sdspi_pkg::P_WR_DATA;
                    end else begin
                        res.tx_valid = 1'b1; res.tx_byte = 8'hFD; res.card_select = 1'b1;
                        n_phase = sdspi_pkg::P_WR_STOPPED;
                    end
                end else if (r_cmd == 6'd24) begin
                    res.done_res = 1'b1; res.result_code = sdspi_pkg::RC_ERROR;
                    n_phase = sdspi_pkg::P_IDLE;
                end else begin
                    res.tx_valid = 1'b1; res.tx_byte = 8'hFD; res.card_select = 1'b1;
                    n_phase = sdspi_pkg::P_WR_STOPPED;
                end
            end
            sdspi_pkg::P_WR_STOPPED: begin
                res.done_res = 1'b1;
                res.result_code = (r_blocks != 16'd0) ? sdspi_pkg::RC_ERROR : sdspi_pkg::RC_OK;
                n_phase = sdspi_pkg::P_IDLE;
            end
            default: n_phase = sdspi_pkg::P_IDLE;
        endcase

        // finish init: card type decides the outcome
        if (fin_flag) begin
            res = '0;
            res.done_res = 1'b1;
            res.result_code = (n_kind != 3'd0) ? sdspi_pkg::RC_OK : sdspi_pkg::RC_ERROR;
            n_uninit = (n_kind == 3'd0);
            n_phase = sdspi_pkg::P_IDLE;
            n_bc = (r_phase == sdspi_pkg::P_CMD_POLL) ? r_bc : r_bc + CW'(1);
            n_ret = r_ret; n_cmd = r_cmd;
            n_resp = (r_phase == sdspi_pkg::P_CMD_POLL) ? r_resp : resp_sh;
        end
        res.card_type = n_kind;
        res.not_initialized = n_uninit;
    end

    assign o_result = res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.done_res) |=> (r_phase == sdspi_pkg::P_IDLE))
        else $error("done without return to idle");
    a_txb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !res.tx_valid |-> (res.tx_byte == 8'd0 && !res.card_select))
        else $error("stray tx payload");
    a_want_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.want_write_byte) |=> (r_phase == sdspi_pkg::P_WR_DATA))
        else $error("write byte asked outside data phase");

endmodule

/* hw/rtl/sdspi_out_reg.sv */
module sdspi_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sdspi_pkg::t_result  i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output logic                o_can_load,
    output sdspi_pkg::t_result  o_result
);

    logic r_valid;
    sdspi_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* tb/sd_card_spi_host_engine_unit_tb.sv */
`timescale 1ns / 100ps

module sd_card_spi_host_engine_unit_tb;

    localparam int BLK = 512;
    localparam int CYCLE_LIMIT = 600000;

    class sd_engine_scoreboard;
        sdspi_pkg::t_phase  phase;
        sdspi_pkg::t_ret    ret;
        logic [2:0]  kind;
        logic        uninit;
        logic [9:0]  bcnt;
        logic [15:0] poll;
        logic [5:0]  cmd_idx;
        logic [31:0] arg;
        logic [31:0] ocr;
        logic [15:0] left;
        logic [7:0]  rsp_tries;
        logic [15:0] tok_tries;
        sdspi_pkg::t_result r;
        sdspi_pkg::t_result pending_results[$];
        int          errors;

        function void clear();
            phase = sdspi_pkg::P_IDLE; ret = sdspi_pkg::R_NONE; kind = 0; uninit = 1;
            bcnt = 0; poll = 0;
            cmd_idx = 0; arg = 0; ocr = 0; left = 0;
            rsp_tries = sdspi_pkg::RESET_RESPONSE_TRIES;
            tok_tries = sdspi_pkg::RESET_TOKEN_TRIES;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == sdspi_pkg::CFG_RESPONSE_TRIES) rsp_tries = val[7:0];
            else tok_tries = val;
        endfunction

        function void emit(logic [7:0] b, logic sel);
            r.tx_valid = 1; r.tx_byte = b; r.card_select = sel;
        endfunction

        function void finish_req(logic [1:0] code);
            r.done_res = 1; r.result_code = code; phase = sdspi_pkg::P_IDLE;
        endfunction

        function void begin_cmd(logic [5:0] idx, logic [31:0] a, sdspi_pkg::t_ret rt);
            cmd_idx = idx; arg = a; ret = rt; bcnt = 0; phase = sdspi_pkg::P_CMD_BYTES;
            emit(8'hFF, 0);
        endfunction

        function logic [7:0] cmd_byte(logic [9:0] k);
            logic [31:0] sh;
            if (k == 0) return 8'h40 | {2'b00, cmd_idx};
            if (k <= 4) begin
                sh = arg >> (8 * (4 - k));
                return sh[7:0];
            end
            if (cmd_idx == 0) return 8'h95;
            if (cmd_idx == 8) return 8'h87;
            return 8'h01;
        endfunction

        function void begin_ocr(sdspi_pkg::t_phase p);
            ocr = 0; bcnt = 0; phase = p; emit(8'hFF, 1);
        endfunction

        function void finish_init();
            uninit = (kind == 0);
            finish_req(kind != 0 ? sdspi_pkg::RC_OK : sdspi_pkg::RC_ERROR);
        endfunction

        function void begin_token();
            poll = 1; phase = sdspi_pkg::P_RD_TOKEN; emit(8'hFF, 1);
        endfunction

        function void begin_wr_block();
            bcnt = 0; phase = sdspi_pkg::P_WR_DATA; emit(8'hFC, 1); r.want_write_byte = 1;
        endfunction

        function void wr_stop();
            phase = sdspi_pkg::P_WR_STOPPED; emit(8'hFD, 1);
        endfunction

        function void after_cmd(logic [7:0] rx);
            case (ret)
                sdspi_pkg::R_CMD0:
                    if (rx == 1) begin_cmd(8, 32'h1AA, sdspi_pkg::R_CMD8); else finish_init();
                sdspi_pkg::R_CMD8:
                    if (rx == 1) begin_ocr(sdspi_pkg::P_OCR8);
                    else begin_cmd(55, 0, sdspi_pkg::R_V1_55);
                sdspi_pkg::R_A55:
                    if (rx <= 1) begin_cmd(41, 32'h4000_0000, sdspi_pkg::R_A41);
                    else begin_cmd(58, 0, sdspi_pkg::R_CMD58);
                sdspi_pkg::R_A41:
                    if (rx != 0) begin_cmd(55, 0, sdspi_pkg::R_A55);
                    else begin_cmd(58, 0, sdspi_pkg::R_CMD58);
                sdspi_pkg::R_CMD58:
                    if (rx == 0) begin_ocr(sdspi_pkg::P_OCR58); else finish_init();
                sdspi_pkg::R_V1_55: begin
                    if (rx <= 1) begin_cmd(41, 0, sdspi_pkg::R_V1_41);
                    else begin
                        kind = 1; begin_cmd(1, 0, sdspi_pkg::R_LOOP);
                    end
                end
                sdspi_pkg::R_V1_41: begin
                    if (rx <= 1) begin
                        kind = 2; begin_cmd(55, 0, sdspi_pkg::R_LOOP55);
                    end else begin
                        kind = 1; begin_cmd(1, 0, sdspi_pkg::R_LOOP);
                    end
                end
                sdspi_pkg::R_LOOP55:
                    if (rx > 1) begin_cmd(55, 0, sdspi_pkg::R_LOOP55);
                    else begin_cmd(41, 0, sdspi_pkg::R_LOOP);
                sdspi_pkg::R_LOOP: begin
                    if (rx == 0) begin_cmd(16, BLK, sdspi_pkg::R_CMD16);
                    else if (kind == 2) begin_cmd(55, 0, sdspi_pkg::R_LOOP55);
                    else begin_cmd(1, 0, sdspi_pkg::R_LOOP);
                end
                sdspi_pkg::R_CMD16: begin
                    if (rx != 0) kind = 0;
                    finish_init();
                end
                sdspi_pkg::R_RD: if (rx == 0) begin_token(); else finish_req(sdspi_pkg::RC_ERROR);
                sdspi_pkg::R_WR:
                    if (rx == 0) begin_wr_block(); else finish_req(sdspi_pkg::RC_ERROR);
                sdspi_pkg::R_STOP:
                    finish_req(left != 0 ? sdspi_pkg::RC_ERROR : sdspi_pkg::RC_OK);
                default: finish_req(sdspi_pkg::RC_ERROR);
            endcase
        endfunction

        function void start_xfer(logic [31:0] sec, logic [15:0] cnt, logic [7:0] drv, bit wr);
            logic [31:0] addr;
            addr = sec;
            if (drv != 0 || cnt == 0) begin
                finish_req(sdspi_pkg::RC_PARAM);
                return;
            end
            if (uninit) begin
                finish_req(sdspi_pkg::RC_NOTRDY);
                return;
            end
            if (!kind[2]) addr = sec * BLK;
            left = cnt;
            if (wr) begin_cmd(cnt == 1 ? 24 : 25, addr, sdspi_pkg::R_WR);
            else begin_cmd(cnt == 1 ? 17 : 18, addr, sdspi_pkg::R_RD);
        endfunction

        // work out the result of one accepted item and queue it
        function void note_input(logic [1:0] op, logic [7:0] rx, logic [7:0] wb,
                                 logic [31:0] sec, logic [15:0] cnt, logic [7:0] drv);
            r = '0;
            case (phase)
                sdspi_pkg::P_IDLE: begin
                    if (op == sdspi_pkg::OP_INIT) begin
                        if (drv != 0) finish_req(sdspi_pkg::RC_PARAM);
                        else begin
                            kind = 0; uninit = 1; bcnt = 1; phase = sdspi_pkg::P_INIT_CLK;
                            emit(8'hFF, 0);
                        end
                    end else if (op == sdspi_pkg::OP_READ) start_xfer(sec, cnt, drv, 0);
                    else if (op == sdspi_pkg::OP_WRITE) start_xfer(sec, cnt, drv, 1);
                end
                sdspi_pkg::P_INIT_CLK: begin
                    if (bcnt < 10) begin
                        bcnt++; emit(8'hFF, 0);
                    end else begin_cmd(0, 0, sdspi_pkg::R_CMD0);
                end
                sdspi_pkg::P_CMD_BYTES: begin
                    if (bcnt < 6) begin
                        emit(cmd_byte(bcnt), 1); bcnt++;
                    end else begin
                        poll = 1; phase = sdspi_pkg::P_CMD_POLL; emit(8'hFF, 1);
                    end
                end
                sdspi_pkg::P_CMD_POLL: begin
                    if (rx[7] && poll < {8'd0, rsp_tries}) begin
                        poll++; emit(8'hFF, 1);
                    end else after_cmd(rx);
                end
                sdspi_pkg::P_OCR8, sdspi_pkg::P_OCR58: begin
                    ocr = {ocr[23:0], rx};
                    bcnt++;
                    if (bcnt < 4) emit(8'hFF, 1);
                    else if (phase == sdspi_pkg::P_OCR8) begin
                        if (ocr[15:0] == 16'h01AA) begin_cmd(55, 0, sdspi_pkg::R_A55);
                        else finish_init();
                    end else begin
                        kind = ocr[30] ? 3'd6 : 3'd2;
                        finish_init();
                    end
                end
                sdspi_pkg::P_RD_TOKEN: begin
                    if (rx == 8'hFF && poll < tok_tries) begin
                        poll++; emit(8'hFF, 1);
                    end else if (rx == 8'hFE) begin
                        bcnt = 0; phase = sdspi_pkg::P_RD_DATA; emit(8'hFF, 1);
                    end else if (cmd_idx == 17) finish_req(sdspi_pkg::RC_ERROR);
                    else begin_cmd(12, 0, sdspi_pkg::R_STOP);
                end
                sdspi_pkg::P_RD_DATA: begin
                    r.read_valid = 1; r.read_byte = rx;
                    bcnt++;
                    emit(8'hFF, 1);
                    if (bcnt >= BLK) phase = sdspi_pkg::P_RD_CRC;
                end
                sdspi_pkg::P_RD_CRC: begin
                    emit(8'hFF, 1); phase = sdspi_pkg::P_RD_END;
                end
                sdspi_pkg::P_RD_END: begin
                    if (left != 0) left--;
                    if (cmd_idx == 17) finish_req(sdspi_pkg::RC_OK);
                    else if (left != 0) begin_token();
                    else begin_cmd(12, 0, sdspi_pkg::R_STOP);
                end
                sdspi_pkg::P_WR_DATA: begin
                    emit(wb, 1);
                    bcnt++;
                    if (bcnt < BLK) r.want_write_byte = 1; else phase = sdspi_pkg::P_WR_CRC1;
                end
                sdspi_pkg::P_WR_CRC1: begin
                    emit(8'hFF, 1); phase = sdspi_pkg::P_WR_CRC2;
                end
                sdspi_pkg::P_WR_CRC2: begin
                    emit(8'hFF, 1); phase = sdspi_pkg::P_WR_RESP;
                end
                sdspi_pkg::P_WR_RESP: begin
                    emit(8'hFF, 1); phase = sdspi_pkg::P_WR_CHECK;
                end
                sdspi_pkg::P_WR_CHECK: begin
                    if (rx[4:0] == 5'h05) begin
                        if (left != 0) left--;
                        if (cmd_idx == 24) finish_req(sdspi_pkg::RC_OK);
                        else if (left != 0) begin_wr_block();
                        else wr_stop();
                    end else if (cmd_idx == 24) finish_req(sdspi_pkg::RC_ERROR);
                    else wr_stop();
                end
                sdspi_pkg::P_WR_STOPPED:
                    finish_req(left != 0 ? sdspi_pkg::RC_ERROR : sdspi_pkg::RC_OK);
                default: phase = sdspi_pkg::P_IDLE;
            endcase
            r.card_type = kind;
            r.not_initialized = uninit;
            pending_results.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            end
        endfunction

        function void check_result(sdspi_pkg::t_result act, logic hs);
            sdspi_pkg::t_result e;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %h", $time, act);
                return;
            end
            e = pending_results.pop_front();
            cmp("tx_valid", e.tx_valid, act.tx_valid);
            cmp("tx_byte", e.tx_byte, act.tx_byte);
            cmp("card_select", e.card_select, act.card_select);
            cmp("read_valid", e.read_valid, act.read_valid);
            cmp("read_byte", e.read_byte, act.read_byte);
            cmp("want_write_byte", e.want_write_byte, act.want_write_byte);
            cmp("done_res", e.done_res, act.done_res);
            cmp("result_code", e.result_code, act.result_code);
            cmp("card_type", e.card_type, act.card_type);
            cmp("not_initialized", e.not_initialized, act.not_initialized);
            cmp("high_speed", !e.not_initialized, hs);
        endfunction

        // card emulation: a plausible byte for the phase the engine is in
        function logic [7:0] card_byte();
            int p;
            p = $urandom_range(99);
            if (p < 8) return 8'($urandom);
            case (phase)
                sdspi_pkg::P_CMD_POLL: begin
                    if (p < 22) return 8'hFF;
                    case (ret)
                        sdspi_pkg::R_CMD0, sdspi_pkg::R_A55, sdspi_pkg::R_LOOP55: return 8'h01;
                        sdspi_pkg::R_CMD8, sdspi_pkg::R_V1_55: return (p < 75) ? 8'h01 : 8'h05;
                        sdspi_pkg::R_A41, sdspi_pkg::R_LOOP: return (p < 70) ? 8'h00 : 8'h01;
                        sdspi_pkg::R_V1_41:
                            return (p < 60) ? 8'h00 : (p < 80 ? 8'h01 : 8'h05);
                        default: return 8'h00;
                    endcase
                end
                sdspi_pkg::P_OCR8: case (bcnt)
                    0, 1: return 8'h00;
                    2: return 8'h01;
                    default: return 8'hAA;
                endcase
                sdspi_pkg::P_RD_TOKEN: return (p < 25) ? 8'hFF : 8'hFE;
                sdspi_pkg::P_WR_CHECK: return {3'($urandom_range(7)), 5'h05};
                default: return 8'($urandom);
            endcase
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_cfg_we, i_valid, i_ready;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic [1:0]  i_opcode;
    logic [7:0]  i_rx_byte, i_write_byte, i_drive_number;
    logic [31:0] i_sector;
    logic [15:0] i_block_count;
    logic        o_ready, o_valid, o_tx_valid, o_card_select, o_read_valid;
    logic        o_want_write_byte, o_done_res, o_not_initialized, o_high_speed;
    logic [7:0]  o_tx_byte, o_read_byte;
    logic [1:0]  o_result_code;
    logic [2:0]  o_card_type;

    sd_card_spi_host_engine_unit u_dut (.*);

    sd_engine_scoreboard sb;
    int  cycles;
    int  items;
    bit  calm;

    always begin
        i_clk = 1; #5;
        i_clk = 0; #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sd_card_spi_host_engine_unit verification failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_tx_valid, o_tx_byte, o_card_select, o_read_valid, o_read_byte,
                             o_want_write_byte, o_done_res, o_result_code, o_card_type,
                             o_not_initialized}, o_high_speed);

    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 22);

    task automatic send_item(logic [1:0] op, logic [31:0] sec, logic [15:0] cnt, logic [7:0] drv);
        @(negedge i_clk);
        i_opcode = op; i_rx_byte = sb.card_byte(); i_write_byte = 8'($urandom);
        i_sector = sec; i_block_count = cnt; i_drive_number = drv;
        i_valid = 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(i_opcode, i_rx_byte, i_write_byte, i_sector, i_block_count,
                      i_drive_number);
        items++;
        calm = (items > 600 && items < 900);
        if (!calm && $urandom_range(99) < 22) begin
            @(negedge i_clk);
            i_valid = 0;
            repeat ($urandom_range(1)) @(negedge i_clk);
        end
    endtask

    // one request, then card bytes until the engine is idle again
    task automatic run_request(logic [1:0] op, logic [31:0] sec, logic [15:0] cnt,
                               logic [7:0] drv);
        send_item(op, sec, cnt, drv);
        while (sb.phase != sdspi_pkg::P_IDLE)
            send_item(($urandom_range(99) < 15) ? 2'($urandom) : sdspi_pkg::OP_BYTE,
                      $urandom, 16'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_valid = 0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we = 1; i_cfg_index = idx; i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 0; i_cfg_data = 16'($urandom);
    endtask

    initial begin
        int          req;
        int          p;
        logic [15:0] cnt;
        logic [7:0]  drv;
        logic [15:0] rv, tv;
        sb = new();
        sb.clear();
        cycles = 0; items = 0; calm = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_valid = 0; i_ready = 0; i_opcode = sdspi_pkg::OP_BYTE; i_rx_byte = 0;
        i_write_byte = 0;
        i_sector = 0; i_block_count = 0; i_drive_number = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;

        // directed: errors before init, then init with extreme tries
        send_item(sdspi_pkg::OP_BYTE, 0, 0, 0);
        run_request(sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 16'd1, 0);
        run_request(sdspi_pkg::OP_WRITE, 0, 16'hFFFF, 0);
        run_request(sdspi_pkg::OP_INIT, 0, 0, 8'hFF);
        run_request(sdspi_pkg::OP_READ, 0, 16'd0, 0);
        run_request(sdspi_pkg::OP_WRITE, 5, 16'd2, 8'h01);
        write_reg(sdspi_pkg::CFG_RESPONSE_TRIES, 16'd0);
        write_reg(sdspi_pkg::CFG_TOKEN_TRIES, 16'd0);
        run_request(sdspi_pkg::OP_INIT, 0, 0, 0);
        write_reg(sdspi_pkg::CFG_RESPONSE_TRIES, 16'd255);
        write_reg(sdspi_pkg::CFG_TOKEN_TRIES, 16'hFFFF);
        run_request(sdspi_pkg::OP_INIT, 0, 0, 0);

        req = 0;
        while (items < 1450) begin
            if (req % 7 == 6) begin
                p = $urandom_range(3);
                rv = (p == 0) ? 16'd1 : (p == 1) ? 16'd255 : (p == 2) ? 16'd0 : 16'($urandom);
                p = $urandom_range(3);
                tv = (p == 0) ? 16'd1 : (p == 1) ? 16'hFFFF : (p == 2) ? 16'd3 : 16'($urandom);
                write_reg(sdspi_pkg::CFG_RESPONSE_TRIES, rv);
                write_reg(sdspi_pkg::CFG_TOKEN_TRIES, tv);
            end
            p = $urandom_range(99);
            cnt = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 3)) : 16'($urandom);
            drv = ($urandom_range(99) < 8) ? 8'($urandom_range(1, 255)) : 8'd0;
            // large counts only where they end at once
            if (cnt > 3 && drv == 0) drv = 8'($urandom_range(1, 255));
            // stay near the item budget: one block costs about 530 items
            if (p >= 30 && !sb.uninit && drv == 0) begin
                while (cnt > 16'd1 && items + 530 * int'(cnt) > 1650) cnt--;
                if (items + 530 > 1650) drv = 8'd1;
            end
            if (p < 10) send_item(sdspi_pkg::OP_BYTE, $urandom, 16'($urandom), 8'($urandom));
            else if (p < 30 || sb.uninit)
                run_request(sdspi_pkg::OP_INIT, $urandom, 16'($urandom), drv);
            else if (p < 65) run_request(sdspi_pkg::OP_READ, $urandom, cnt, drv);
            else run_request(sdspi_pkg::OP_WRITE, $urandom, cnt, drv);
            req++;
        end

        @(negedge i_clk);
        i_valid = 0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("sd_card_spi_host_engine_unit verification clean");
        else
            $display("sd_card_spi_host_engine_unit verification failed");
        $finish;
    end
endmodule

/* sd_card_spi_host_engine_unit.f */
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_core.sv
hw/rtl/sdspi_out_reg.sv
hw/rtl/sd_card_spi_host_engine_unit.sv
tb/sd_card_spi_host_engine_unit_tb.sv
